[rtl/core/u8dec_pkg.sv]
// Shared constants, types and the letter case-swap function for the UTF-8 decoder.
package u8dec_pkg;

  // Byte patterns of the UTF-8 lead bytes
  localparam logic [7:0] LEAD2_MASK  = 8'b1110_0000;
  localparam logic [7:0] LEAD2_CODE  = 8'b1100_0000;
  localparam logic [7:0] LEAD3_MASK  = 8'b1111_0000;
  localparam logic [7:0] LEAD3_CODE  = 8'b1110_0000;
  localparam logic [7:0] ASCII_MAX   = 8'h7f;

  // Pending counts after a lead byte
  localparam logic [1:0] PEND_NONE   = 2'd0;
  localparam logic [1:0] PEND_ONE    = 2'd1;
  localparam logic [1:0] PEND_TWO    = 2'd2;

  // Letter ranges for the case swap
  localparam logic [7:0] UPPER_LO    = 8'h40;
  localparam logic [7:0] UPPER_HI    = 8'h5b;
  localparam logic [7:0] LOWER_LO    = 8'h60;
  localparam logic [7:0] LOWER_HI    = 8'h7b;
  localparam logic [7:0] CASE_DELTA  = 8'h20;

  localparam logic [7:0] MISSING_RST = 8'd63;

  localparam int unsigned CP_W   = 16;
  localparam int unsigned CHAR_W = 8;

  // One decoded result
  typedef struct packed {
    logic              bad_lead;
    logic [CHAR_W-1:0] petscii_char;
    logic [CP_W-1:0]   code_point;
  } result_t;

  // Swap the case of ASCII letters, pass other bytes through
  function automatic logic [7:0] swap_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c > UPPER_LO && c < UPPER_HI) begin
      r = c + CASE_DELTA;
    end else if (c > LOWER_LO && c < LOWER_HI) begin
      r = c - CASE_DELTA;
    end
    return r;
  endfunction

endpackage

[rtl/core/u8dec_petscii.sv]
// Maps a decoded code point to its PETSCII byte.
module u8dec_petscii (
  input  logic [u8dec_pkg::CP_W-1:0]   code_point,
  input  logic [u8dec_pkg::CHAR_W-1:0] missing_char,
  output logic [u8dec_pkg::CHAR_W-1:0] petscii_char
);

  // Use the missing character above the Latin-1 range, else swap letter case
  always_comb begin
    if (code_point[u8dec_pkg::CP_W-1:u8dec_pkg::CHAR_W] != '0) begin
      petscii_char = missing_char;
    end else begin
      petscii_char = u8dec_pkg::swap_case(code_point[u8dec_pkg::CHAR_W-1:0]);
    end
  end

endmodule

[rtl/core/utf8_to_bmp_petscii_decoder.sv]
// Top level: UTF-8 byte stream to BMP code point and PETSCII decoder.
//
//  channel | direction | width | contents
//  in_     | slave     | 8     | tdata: in_byte
//  out_    | master    | 24+1  | tdata: code_point, petscii_char; tuser: bad_lead
//  cfg_    | slave     | 8     | data: missing_char
//
// A result is valid once its last byte has passed the input register and been
// decoded into the result register. One byte is accepted every cycle unless a
// stalled result holds the decode stage. Lead bytes and inner continuation bytes
// give no result.
// Reset (synchronous, rst_n low) clears the pending count, accumulator, valids
// and sets missing_char to 63. A stalled result holds the decode stage; the
// input register still fills, then in_tready drops.
module utf8_to_bmp_petscii_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [15:0] code_point, [23:16] petscii_char
  output logic        out_tuser,   // [0] bad_lead
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data     // [7:0] missing_char
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic [7:0]  missing_char_r;
  logic [1:0]  pending_r, pending_nxt;
  logic [15:0] partial_r, partial_nxt;
  logic        emit;
  logic        advance;
  logic [15:0] cp;
  logic        bad;
  logic [7:0]  petscii;
  logic        out_valid_r;
  u8dec_pkg::result_t res_r;

  assign cfg_ready = 1'b1;

  // Decode stage moves when its byte is present and the result slot is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Hold the incoming byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // Take the missing character register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      missing_char_r <= u8dec_pkg::MISSING_RST;
    end else if (cfg_valid && cfg_ready) begin
      missing_char_r <= cfg_data;
    end
  end

  // Decode one byte against the pending sequence
  always_comb begin
    pending_nxt = pending_r;
    partial_nxt = partial_r;
    emit        = 1'b0;
    bad         = 1'b0;
    cp          = '0;
    if (pending_r != u8dec_pkg::PEND_NONE) begin
      partial_nxt = {partial_r[9:0], in_byte_r[5:0]};
      pending_nxt = pending_r - 2'd1;
      emit        = (pending_r == u8dec_pkg::PEND_ONE);
      cp          = partial_nxt;
    end else if (in_byte_r <= u8dec_pkg::ASCII_MAX) begin
      emit = 1'b1;
      cp   = {8'd0, in_byte_r};
    end else if ((in_byte_r & u8dec_pkg::LEAD2_MASK) == u8dec_pkg::LEAD2_CODE) begin
      partial_nxt = {11'd0, in_byte_r[4:0]};
      pending_nxt = u8dec_pkg::PEND_ONE;
    end else if ((in_byte_r & u8dec_pkg::LEAD3_MASK) == u8dec_pkg::LEAD3_CODE) begin
      partial_nxt = {12'd0, in_byte_r[3:0]};
      pending_nxt = u8dec_pkg::PEND_TWO;
    end else begin
      emit = 1'b1;
      bad  = 1'b1;
    end
  end

  u8dec_petscii u_petscii (
    .code_point   (cp),
    .missing_char (missing_char_r),
    .petscii_char (petscii)
  );

  // Advance the sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= u8dec_pkg::PEND_NONE;
      partial_r <= '0;
    end else if (advance) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
    end
  end

  // Hold the result until the request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= '{bad_lead: bad, petscii_char: petscii, code_point: cp};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.petscii_char, res_r.code_point};
  assign out_tuser  = res_r.bad_lead;

`ifndef NO_ASSERTIONS
  // A three-count never arises
  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3) else $error("pending count reached three");

  // A bad lead carries code point and PETSCII zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.bad_lead) |-> (res_r.code_point == '0 && res_r.petscii_char == '0))
    else $error("bad lead result not zero");

  // Code points above Latin-1 map to the missing character
  a_missing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.code_point[15:8] != '0) |-> res_r.petscii_char == missing_char_r)
    else $error("wide code point not mapped to missing character");

  // No result leaves while a sequence is still open
  a_no_emit_midseq: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && pending_nxt != u8dec_pkg::PEND_NONE) |-> !emit)
    else $error("result emitted mid sequence");
`endif

endmodule

[sim/utf8_decoder_checker.sv]
`timescale 1ns / 100ps
// Checker for the UTF-8 decoder: watches all three channels, predicts each result and compares.
module utf8_decoder_checker
  import u8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending_results
);

  // Decoder state as seen from the byte stream
  logic [1:0]  seq_left;
  logic [15:0] seq_acc;
  logic [7:0]  miss_char;

  // Decoded characters still owed by the block, oldest first
  result_t     char_queue[$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
    seq_left        = PEND_NONE;
    seq_acc         = '0;
    miss_char       = MISSING_RST;
  end

  // Map a code point to its PETSCII byte: wide points give the missing character,
  // letters swap case, everything else passes through
  function automatic logic [7:0] map_petscii(input logic [15:0] cp, input logic [7:0] miss);
    logic [7:0] c;
    c = cp[7:0];
    if (cp > 16'd255) begin
      return miss;
    end
    if (c >= 8'h41 && c <= 8'h5a) begin
      c = c + 8'h20;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      c = c - 8'h20;
    end
    return c;
  endfunction

  // Advance the decoder by one byte; flag whether a character comes out
  task automatic decode_byte(input logic [7:0] b, output bit emits, output result_t r);
    emits = 1'b0;
    r     = '0;
    if (seq_left != PEND_NONE) begin
      // Following byte: low six bits go in whatever the top bits say
      seq_acc  = {seq_acc[9:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == PEND_NONE) begin
        emits = 1'b1;
        r.code_point = seq_acc;
      end
    end else if (b <= ASCII_MAX) begin
      emits = 1'b1;
      r.code_point = {8'h00, b};
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      seq_acc  = {11'd0, b[4:0]};
      seq_left = PEND_ONE;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      seq_acc  = {12'd0, b[3:0]};
      seq_left = PEND_TWO;
    end else begin
      // Stray continuation, four-byte lead or byte above 0xf7
      emits      = 1'b1;
      r.bad_lead = 1'b1;
    end
    if (emits) begin
      r.petscii_char = r.bad_lead ? 8'h00 : map_petscii(r.code_point, miss_char);
    end
  endtask

  task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      fail_count = fail_count + 1;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Compare results first, then take configuration and input requests of the same edge
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    result_t pred;
    bit      emits;
    if (!rst_n) begin
      seq_left  = PEND_NONE;
      seq_acc   = '0;
      miss_char = MISSING_RST;
      char_queue.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.code_point   = out_tdata[15:0];
        got.petscii_char = out_tdata[23:16];
        got.bad_lead     = out_tuser;
        if (char_queue.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: result with none expected, expected nothing, actual %h/%h/%b",
                   $time, got.code_point, got.petscii_char, got.bad_lead);
        end else begin
          want = char_queue.pop_front();
          report("code_point", want.code_point, got.code_point);
          report("petscii_char", {8'h00, want.petscii_char}, {8'h00, got.petscii_char});
          report("bad_lead", {15'd0, want.bad_lead}, {15'd0, got.bad_lead});
        end
      end
      if (cfg_valid && cfg_ready) begin
        miss_char = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, emits, pred);
        if (emits) begin
          char_queue.push_back(pred);
        end
      end
    end
    pending_results = char_queue.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench top: clock, reset, byte stream stimulus and verdict for the UTF-8 decoder.
module tb;
  import u8dec_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [7:0]  cfg_data   = 8'h00;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_ready;

  int          fail_count;
  int          pending_results;

  // Idling controls and the long receiver hold-off
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_go    = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left  = 0;

  // Edges of each field plus two-byte, three-byte, bad-lead and unchecked-follower cases
  logic [7:0]  directed_bytes [28] = '{
    8'h00, 8'h7f, 8'h41, 8'h5a, 8'h5b, 8'h61, 8'h7a, 8'h7b, 8'h40, 8'h60,
    8'hc1, 8'h81,                  // two bytes folding back to a letter
    8'hdf, 8'hbf,                  // widest two-byte point
    8'he2, 8'h82, 8'hac,           // three bytes
    8'hef, 8'hbf, 8'hbf,           // widest three-byte point
    8'h80, 8'hff, 8'hf0,           // stray continuation, invalid 0xff and four-byte lead
    8'hc5, 8'h41,                  // ASCII taken as a follower
    8'he1, 8'hc3, 8'hff            // lead and invalid bytes taken as followers
  };

  utf8_to_bmp_petscii_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  utf8_decoder_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, one long hold-off counted here
  always @(negedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= 300;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!rx_idle_en) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 29);
    end
  end

  // Offer one byte, idling first at random; return at the falling edge after the request
  task automatic send_byte(input logic [7:0] b);
    while (tx_idle_en && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send one unit: mostly well-formed sequences, some noise and broken sequences
  task automatic send_random_unit(output int nbytes);
    int kind;
    kind = $urandom_range(99);
    if (kind < 25) begin
      send_byte(8'($urandom_range(127)));
      nbytes = 1;
    end else if (kind < 55) begin
      send_byte(LEAD2_CODE | 8'($urandom_range(31)));
      send_byte(8'h80 | 8'($urandom_range(63)));
      nbytes = 2;
    end else if (kind < 85) begin
      send_byte(LEAD3_CODE | 8'($urandom_range(15)));
      send_byte(8'h80 | 8'($urandom_range(63)));
      send_byte(8'h80 | 8'($urandom_range(63)));
      nbytes = 3;
    end else if (kind < 95) begin
      send_byte(8'($urandom_range(255)));
      nbytes = 1;
    end else begin
      // Broken sequence: lead then any byte at all
      send_byte(LEAD2_CODE | 8'($urandom_range(31)));
      send_byte(8'($urandom_range(255)));
      nbytes = 2;
    end
  endtask

  task automatic run_random(input int count);
    int sent;
    int k;
    sent = 0;
    while (sent < count) begin
      send_random_unit(k);
      sent = sent + k;
    end
  endtask

  // Drop valid, wait for every owed character, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_missing(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed bytes under the reset missing character
    foreach (directed_bytes[i]) begin
      send_byte(directed_bytes[i]);
    end

    settle();
    write_missing(8'h00);
    run_random(300);

    // Stretch with no idling on either side, then one with idling again
    settle();
    write_missing(8'hff);
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    run_random(150);
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    run_random(100);

    // Hold the receiver off while requests keep coming
    settle();
    write_missing(8'($urandom_range(255)));
    hold_go    <= 1'b1;
    tx_idle_en = 1'b0;
    run_random(60);
    tx_idle_en = 1'b1;
    run_random(450);

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/core/u8dec_pkg.sv
rtl/core/u8dec_petscii.sv
rtl/core/utf8_to_bmp_petscii_decoder.sv
sim/utf8_decoder_checker.sv
sim/tb.sv
